FILE: rtl/indexed_chipset_regs_shadow_decode_top_macros.svh
// Assertion macros used by the top-level RTL file of the chipset register block.
`ifndef INDEXED_CHIPSET_REGS_SHADOW_DECODE_TOP_MACROS_SVH
`define INDEXED_CHIPSET_REGS_SHADOW_DECODE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define ICSD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define ICSD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define ICSD_ASSERT_IMP(label, clk, rst, ante, cons)

`define ICSD_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/icsd_pkg.sv
package icsd_pkg;

  localparam int SEG_COUNT   = 12;
  localparam int STORE_DEPTH = 18;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int REMAP_W     = 14;

  localparam logic [1:0] VAR_A = 2'd0;
  localparam logic [1:0] VAR_B = 2'd1;
  localparam logic [1:0] VAR_C = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_VARIANT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = 2'd1;

  localparam logic [15:0] MEM_RESET_KB = 16'd4096;
  localparam logic [15:0] MEM_REMAP_KB = 16'd8192;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [15:0] PORT_INDEX = 16'h0022;
  localparam logic [15:0] PORT_DATA  = 16'h0024;

  localparam logic [7:0] BASE_AB   = 8'h0f;
  localparam logic [7:0] BASE_C    = 8'h20;
  localparam logic [7:0] IDX_AB_LO = 8'h10;
  localparam logic [7:0] IDX_AB_HI = 8'h1c;
  localparam logic [7:0] IDX_C_HI  = 8'h2b;
  localparam logic [7:0] IDX_NONE  = 8'hff;

  localparam logic [7:0] MASK_C5 = 8'hf8;
  localparam logic [7:0] MASK_C8 = 8'he3;

  localparam logic [STORE_AW-1:0] REG_00 = 5'h00;
  localparam logic [STORE_AW-1:0] REG_01 = 5'h01;
  localparam logic [STORE_AW-1:0] REG_02 = 5'h02;
  localparam logic [STORE_AW-1:0] REG_03 = 5'h03;
  localparam logic [STORE_AW-1:0] REG_04 = 5'h04;
  localparam logic [STORE_AW-1:0] REG_05 = 5'h05;
  localparam logic [STORE_AW-1:0] REG_06 = 5'h06;
  localparam logic [STORE_AW-1:0] REG_07 = 5'h07;
  localparam logic [STORE_AW-1:0] REG_08 = 5'h08;
  localparam logic [STORE_AW-1:0] REG_09 = 5'h09;
  localparam logic [STORE_AW-1:0] REG_0A = 5'h0a;
  localparam logic [STORE_AW-1:0] REG_0B = 5'h0b;
  localparam logic [STORE_AW-1:0] REG_0C = 5'h0c;
  localparam logic [STORE_AW-1:0] REG_0D = 5'h0d;
  localparam logic [STORE_AW-1:0] REG_SP0 = 5'h10;
  localparam logic [STORE_AW-1:0] REG_SP1 = 5'h11;

  typedef struct packed {
    logic        req_type;
    logic [15:0] port_address;
    logic [7:0]  write_value;
  } icsd_item_t;

  typedef struct packed {
    logic [SEG_COUNT-1:0] read_int;
    logic [SEG_COUNT-1:0] write_int;
    logic [SEG_COUNT-1:0] write_dis;
  } icsd_route_t;

  typedef struct packed {
    logic [7:0]         read_data;
    icsd_route_t        route;
    logic               bios_shadow_on;
    logic [REMAP_W-1:0] remap_start_kb;
    logic               soft_reset_pulse;
    logic               halt_reset_enable;
    logic               a20_alternate;
    logic               ext_cache_enable;
  } icsd_result_t;

  function automatic logic [1:0] icsd_eff(input logic [1:0] code);
    icsd_eff = (code >= VAR_C) ? VAR_C : code;
  endfunction

  function automatic logic [7:0] icsd_default(input logic [1:0] v,
                                              input logic [STORE_AW-1:0] a);
    logic b;
    b = (v == VAR_B);
    icsd_default = 8'h00;
    if (v == VAR_C) begin
      case (a)
        REG_02:  icsd_default = 8'h84;
        REG_04:  icsd_default = 8'h07;
        REG_05:  icsd_default = 8'hf0;
        REG_06:  icsd_default = 8'h30;
        REG_07:  icsd_default = 8'h91;
        REG_08:  icsd_default = 8'h80;
        REG_09:  icsd_default = 8'h10;
        REG_0A:  icsd_default = 8'h80;
        REG_0B:  icsd_default = 8'h10;
        default: icsd_default = 8'h00;
      endcase
    end else begin
      case (a)
        REG_01:  icsd_default = 8'h01;
        REG_02:  icsd_default = 8'he0;
        REG_04:  icsd_default = b ? 8'h07 : 8'h77;
        REG_05:  icsd_default = 8'h60;
        REG_06:  icsd_default = 8'h10;
        REG_07:  icsd_default = 8'h50;
        REG_09:  icsd_default = b ? 8'h80 : 8'he0;
        REG_0A:  icsd_default = 8'h10;
        REG_0B:  icsd_default = b ? 8'h80 : 8'h10;
        REG_0C:  icsd_default = 8'h10;
        REG_0D:  icsd_default = b ? 8'h91 : 8'h80;
        default: icsd_default = 8'h00;
      endcase
    end
  endfunction

endpackage

FILE: rtl/icsd_route.sv
module icsd_route (
  input  logic [7:0]           r2,
  input  logic [7:0]           r3,
  input  logic [7:0]           r6,
  output icsd_pkg::icsd_route_t route
);
  import icsd_pkg::*;

  always_comb begin
    logic master;
    logic enable;
    logic wprot;
    route = '0;
    for (int i = 0; i < SEG_COUNT; i++) begin
      if (i < 4) begin
        master = r6[4];
        wprot  = r6[5];
        enable = r6[i];
      end else if (i < 8) begin
        master = r2[6];
        wprot  = r2[4];
        enable = r3[i-4];
      end else begin
        master = r2[5];
        wprot  = r2[3];
        enable = r3[i-4];
      end
      if (master && enable) begin
        route.read_int[i] = 1'b1;
        if (wprot) begin
          route.write_dis[i] = 1'b1;
        end else begin
          route.write_int[i] = 1'b1;
        end
      end else if (r6[6]) begin
        route.write_int[i] = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/icsd_regs.sv
module icsd_regs (
  input  logic                 clk,
  input  logic                 init,
  input  logic [1:0]           init_variant,
  input  logic [1:0]           variant,
  input  logic [15:0]          memory_size_kb,
  input  logic                 accept,
  input  icsd_pkg::icsd_item_t item,
  output icsd_pkg::icsd_result_t res_next
);
  import icsd_pkg::*;

  logic [7:0]                store [STORE_DEPTH];
  logic [7:0]                index_reg;
  logic [REMAP_W-1:0]        remap_start;
  logic                      halt_flag;
  logic                      a20_flag;
  logic                      ext_flag;

  logic [7:0]                index_next;
  logic                      halt_next;
  logic                      a20_next;
  logic                      ext_next;
  logic                      pulse;
  logic                      remap_eval;
  logic [REMAP_W-1:0]        remap_cand;
  logic                      wr_en;
  logic [STORE_AW-1:0]       wr_addr;
  logic [7:0]                wr_data;
  logic [7:0]                rdata;
  logic                      is_ab;
  logic [7:0]                base;
  logic [7:0]                off;
  logic [7:0]                val;
  logic [7:0]                r1_n;
  logic [7:0]                r2_n;
  logic [7:0]                r3_n;
  logic [7:0]                r6_n;
  icsd_route_t               route;
  logic [SEG_COUNT-1:0]      seg_any;

  assign is_ab = (variant != VAR_C);
  assign base  = is_ab ? BASE_AB : BASE_C;
  assign off   = index_reg - base;
  assign val   = item.write_value;

  always_comb begin
    index_next = index_reg;
    halt_next  = halt_flag;
    a20_next   = a20_flag;
    ext_next   = ext_flag;
    pulse      = 1'b0;
    remap_eval = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = off[STORE_AW-1:0];
    wr_data    = val;
    rdata      = IDX_NONE;
    if (accept) begin
      if (item.req_type == REQ_WRITE) begin
        if (item.port_address == PORT_INDEX) begin
          index_next = val;
        end else if (item.port_address == PORT_DATA) begin
          index_next = IDX_NONE;
          if (is_ab && index_reg <= 8'd1) begin
            wr_en = 1'b1;
            if (index_reg[0]) begin
              wr_addr   = REG_SP1;
              halt_next = val[1];
            end else begin
              wr_addr = REG_SP0;
              pulse   = !store[REG_SP0][5] && val[5];
            end
          end else if (index_reg >= base && off[7:STORE_AW] == '0) begin
            case (off[STORE_AW-1:0])
              REG_00: begin
                if (!is_ab) begin
                  halt_next = val[1];
                  pulse     = !store[REG_00][0] && val[0];
                  wr_en     = 1'b1;
                  wr_data   = {store[REG_00][7:6], val[5:0]};
                end
              end
              REG_01: begin
                wr_en = 1'b1;
                if (is_ab) begin
                  remap_eval = 1'b1;
                end else begin
                  ext_next = val[4];
                end
              end
              REG_05: begin
                wr_en   = 1'b1;
                wr_data = is_ab ? val : (val & MASK_C5);
              end
              REG_04, REG_09, REG_0A, REG_0B: begin
                wr_en = 1'b1;
              end
              REG_07: begin
                wr_en = 1'b1;
                if (is_ab) begin
                  a20_next = val[3];
                end
              end
              REG_08: begin
                wr_en = 1'b1;
                if (is_ab) begin
                  ext_next = store[REG_02][6];
                end else begin
                  wr_data = val & MASK_C8;
                end
              end
              REG_0C, REG_0D: begin
                wr_en = is_ab;
              end
              REG_02, REG_03, REG_06: begin
                wr_en      = 1'b1;
                remap_eval = is_ab;
              end
              default: begin
              end
            endcase
          end
        end
      end else if (item.port_address == PORT_DATA) begin
        index_next = IDX_NONE;
        if (is_ab && index_reg <= 8'd1) begin
          rdata = store[index_reg[0] ? REG_SP1 : REG_SP0];
        end else if (is_ab && (index_reg inside {[IDX_AB_LO:IDX_AB_HI]})) begin
          rdata = store[off[STORE_AW-1:0]];
        end else if (!is_ab && (index_reg inside {[BASE_C:IDX_C_HI]})) begin
          rdata = store[off[STORE_AW-1:0]];
        end
      end
    end
  end

  assign r1_n = (wr_en && wr_addr == REG_01) ? wr_data : store[REG_01];
  assign r2_n = (wr_en && wr_addr == REG_02) ? wr_data : store[REG_02];
  assign r3_n = (wr_en && wr_addr == REG_03) ? wr_data : store[REG_03];
  assign r6_n = (wr_en && wr_addr == REG_06) ? wr_data : store[REG_06];

  icsd_route u_route (
    .r2    (r2_n),
    .r3    (r3_n),
    .r6    (r6_n),
    .route (route)
  );

  assign seg_any = route.read_int | route.write_int | route.write_dis;

  always_comb begin
    remap_cand = '0;
    if (memory_size_kb <= MEM_REMAP_KB && seg_any[11:4] == '0 &&
        r1_n[3:0] != 4'd0 && r1_n[4]) begin
      remap_cand = {r1_n[3:0], 10'd0};
    end
  end

  always_comb begin
    res_next.read_data         = rdata;
    res_next.route             = route;
    res_next.bios_shadow_on    = r2_n[7];
    res_next.remap_start_kb    = remap_eval ? remap_cand : remap_start;
    res_next.soft_reset_pulse  = pulse;
    res_next.halt_reset_enable = halt_next;
    res_next.a20_alternate     = a20_next;
    res_next.ext_cache_enable  = ext_next;
  end

  always_ff @(posedge clk) begin
    if (init) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store[i] <= icsd_default(init_variant, STORE_AW'(i));
      end
      index_reg   <= '0;
      remap_start <= '0;
      halt_flag   <= 1'b0;
      a20_flag    <= 1'b0;
      ext_flag    <= 1'b0;
    end else if (accept) begin
      if (wr_en) begin
        store[wr_addr] <= wr_data;
      end
      index_reg <= index_next;
      halt_flag <= halt_next;
      a20_flag  <= a20_next;
      ext_flag  <= ext_next;
      if (remap_eval) begin
        remap_start <= remap_cand;
      end
    end
  end

endmodule

FILE: rtl/indexed_chipset_regs_shadow_decode_top.sv
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while out_ready is high; the register store is written at most once per item.
// Reset: synchronous; the variant returns to the third one, installed memory to 4096 KB,
// and the register store is loaded with that variant's defaults in the same cycle.
// A write of the variant register reloads the store the same way.
`include "indexed_chipset_regs_shadow_decode_top_macros.svh"

module indexed_chipset_regs_shadow_decode_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [15:0]                     port_address,
  input  logic [7:0]                      write_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      read_data,
  output logic [icsd_pkg::SEG_COUNT-1:0]  seg_read_internal,
  output logic [icsd_pkg::SEG_COUNT-1:0]  seg_write_internal,
  output logic [icsd_pkg::SEG_COUNT-1:0]  seg_write_disabled,
  output logic                            bios_shadow_on,
  output logic [icsd_pkg::REMAP_W-1:0]    remap_start_kb,
  output logic                            soft_reset_pulse,
  output logic                            halt_reset_enable,
  output logic                            a20_alternate,
  output logic                            ext_cache_enable,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [icsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icsd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import icsd_pkg::*;

  logic [1:0]           variant;
  logic [15:0]          installed_kb;
  logic                 cfg_fire;
  logic                 accept;
  logic                 init;
  logic [1:0]           init_variant;
  icsd_item_t           item;
  icsd_result_t         res_next;
  icsd_result_t         res_q;
  logic [SEG_COUNT-1:0] seg_any;

  assign cfg_ready = !rst;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !rst && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;

  assign init         = rst || (cfg_fire && cfg_index == CFG_VARIANT);
  assign init_variant = rst ? VAR_C : icsd_eff(cfg_data[1:0]);

  assign item.req_type     = req_type;
  assign item.port_address = port_address;
  assign item.write_value  = write_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant      <= VAR_C;
      installed_kb <= MEM_RESET_KB;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_VARIANT:  variant      <= icsd_eff(cfg_data[1:0]);
        CFG_MEM_SIZE: installed_kb <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  icsd_regs u_regs (
    .clk            (clk),
    .init           (init),
    .init_variant   (init_variant),
    .variant        (variant),
    .memory_size_kb (installed_kb),
    .accept         (accept),
    .item           (item),
    .res_next       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_next;
    end
  end

  assign read_data          = res_q.read_data;
  assign seg_read_internal  = res_q.route.read_int;
  assign seg_write_internal = res_q.route.write_int;
  assign seg_write_disabled = res_q.route.write_dis;
  assign bios_shadow_on     = res_q.bios_shadow_on;
  assign remap_start_kb     = res_q.remap_start_kb;
  assign soft_reset_pulse   = res_q.soft_reset_pulse;
  assign halt_reset_enable  = res_q.halt_reset_enable;
  assign a20_alternate      = res_q.a20_alternate;
  assign ext_cache_enable   = res_q.ext_cache_enable;

  assign seg_any = seg_read_internal | seg_write_internal | seg_write_disabled;

  `ICSD_ASSERT_IMP(a_write_paths_disjoint, clk, rst, out_valid, (seg_write_internal & seg_write_disabled) == '0)
  `ICSD_ASSERT_IMP(a_protect_needs_read, clk, rst, out_valid, (seg_write_disabled & ~seg_read_internal) == '0)
  `ICSD_ASSERT_IMP(a_remap_needs_clear_segs, clk, rst, out_valid && remap_start_kb != '0, seg_any[11:4] == '0)
  `ICSD_ASSERT_NXT(a_write_reads_ff, clk, rst, accept && req_type == REQ_WRITE, read_data == IDX_NONE)
  `ICSD_ASSERT_NXT(a_pulse_needs_data_write, clk, rst, accept && !(req_type == REQ_WRITE && port_address == PORT_DATA), !soft_reset_pulse)

endmodule
